// ===== src/var_pkg.sv =====
// Shared constants and types for the vector alignment rotation block.
`default_nettype none
package var_pkg;
    localparam int IN_BITS_DEF = 24;
    localparam int CW = 32;
    localparam int Q30 = 30;
    localparam int SQ_W = 64;
    localparam int SQRT_LAT = SQ_W / 2;
    localparam int U_Q = 31;
    localparam int U_NW = U_Q + Q30 + 1;
    localparam int DIV1_LAT = U_Q + 1;
    localparam int NORM_LAT = 5 + SQRT_LAT + DIV1_LAT + 1;
    localparam int E_Q = 33;
    localparam int E_NW = 64;
    localparam int DIV2_LAT = E_Q + 1;
    localparam int PRE_LAT = NORM_LAT + 5 + DIV2_LAT + 1;
    localparam int MARGIN_W = 17;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 17'd16;
    localparam logic signed [17:0] Q16_ONE = 18'sd65536;

    typedef logic signed [CW-1:0] comp_t;
    typedef logic [CW-1:0] ucomp_t;
endpackage
`default_nettype wire

// ===== src/var_delay.sv =====
// Enabled shift line that delays a word by a fixed number of stages.
`default_nettype none
module var_delay #(
    parameter int W = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic      [W-1:0] q
);
    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            pipe_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[DEPTH-1];
endmodule
`default_nettype wire

// ===== src/var_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module var_isqrt #(
    parameter int XW = 64
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [XW-1:0]   x,
    output logic      [XW/2-1:0] root
);
    localparam int RW = XW / 2;

    logic [RW+1:0] rem_reg  [RW];
    logic [RW+1:0] rem_next [RW];
    logic [RW-1:0] root_reg [RW];
    logic [RW-1:0] root_next[RW];
    logic [XW-1:0] x_reg    [RW];
    logic [XW-1:0] x_next   [RW];

    always_comb
    begin
        logic [RW+1:0] pr;
        logic [RW-1:0] pt;
        logic [XW-1:0] px;
        logic [RW+3:0] rt;
        logic [RW+3:0] tr;
        for (int j = 0; j < RW; j++)
        begin
            if (j == 0)
            begin
                pr = '0;
                pt = '0;
                px = x;
            end
            else
            begin
                pr = rem_reg[j-1];
                pt = root_reg[j-1];
                px = x_reg[j-1];
            end
            rt = {pr, px[XW-1:XW-2]};
            tr = {2'b00, pt, 2'b01};
            if (rt >= tr)
            begin
                rem_next[j]  = (RW+2)'(rt - tr);
                root_next[j] = {pt[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = rt[RW+1:0];
                root_next[j] = {pt[RW-2:0], 1'b0};
            end
            x_next[j] = px << 2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < RW; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                x_reg[j]    <= x_next[j];
            end
        end
    end

    assign root = root_reg[RW-1];
endmodule
`default_nettype wire

// ===== src/var_div.sv =====
// Pipelined restoring divider with overflow saturation, one quotient bit per stage.
`default_nettype none
module var_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QW = 33
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW:0]   quo
);
    localparam int HW = NW - QW;

    logic [DW-1:0] rem_reg  [QW+1];
    logic [DW-1:0] rem_next [QW+1];
    logic [DW-1:0] den_reg  [QW+1];
    logic [DW-1:0] den_next [QW+1];
    logic [QW-1:0] lo_reg   [QW+1];
    logic [QW-1:0] lo_next  [QW+1];
    logic [QW-1:0] q_reg    [QW+1];
    logic [QW-1:0] q_next   [QW+1];
    logic          ovf_reg  [QW+1];
    logic          ovf_next [QW+1];

    always_comb
    begin
        logic [HW-1:0] hi;
        logic [DW:0]   rt;
        logic          b;
        hi          = num[NW-1:QW];
        ovf_next[0] = {{DW{1'b0}}, hi} >= {{HW{1'b0}}, den};
        rem_next[0] = DW'(hi);
        den_next[0] = den;
        lo_next[0]  = num[QW-1:0];
        q_next[0]   = '0;
        for (int i = 1; i <= QW; i++)
        begin
            rt = {rem_reg[i-1], lo_reg[i-1][QW-1]};
            b  = rt >= {1'b0, den_reg[i-1]};
            if (b)
            begin
                rem_next[i] = DW'(rt - {1'b0, den_reg[i-1]});
            end
            else
            begin
                rem_next[i] = rt[DW-1:0];
            end
            q_next[i]   = {q_reg[i-1][QW-2:0], b};
            lo_next[i]  = lo_reg[i-1] << 1;
            den_next[i] = den_reg[i-1];
            ovf_next[i] = ovf_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QW; i++)
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_next[i];
                lo_reg[i]  <= lo_next[i];
                q_reg[i]   <= q_next[i];
                ovf_reg[i] <= ovf_next[i];
            end
        end
    end

    assign quo = ovf_reg[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, q_reg[QW]};
endmodule
`default_nettype wire

// ===== src/var_norm.sv =====
// Normalizes one integer 3-vector to a Q30 unit vector.
`default_nettype none
module var_norm
    import var_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire comp_t c [3],
    output comp_t      u [3],
    output logic       nz
);
    ucomp_t      mag1_reg [3];
    logic [2:0]  sgn1_reg;
    ucomp_t      mx1_reg;
    ucomp_t      mag2_reg [3];
    logic [2:0]  sgn2_reg;
    logic [4:0]  k2_reg;
    logic        nz2_reg;
    ucomp_t      ms3_reg [3];
    logic [2:0]  sgn3_reg;
    logic        nz3_reg;
    ucomp_t      ms4_reg [3];
    logic [63:0] sq4_reg [3];
    logic [2:0]  sgn4_reg;
    logic        nz4_reg;
    ucomp_t      ms5_reg [3];
    logic [63:0] sum5_reg;
    logic [2:0]  sgn5_reg;
    logic        nz5_reg;
    comp_t       u_reg [3];
    logic        nz_reg;

    ucomp_t      mag1_next [3];
    ucomp_t      mx1_next;
    logic [4:0]  hb;
    logic [4:0]  k2_next;
    ucomp_t      n;
    logic [3*CW+3:0] side_a;
    ucomp_t      ms_d [3];
    logic [2:0]  sgn_d;
    logic        nz_d;
    logic [3:0]  side_b;
    logic [2:0]  sgn_e;
    logic        nz_e;
    logic [U_Q:0] q [3];
    logic [U_NW-1:0] num [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = c[i][CW-1] ? ucomp_t'(-c[i]) : ucomp_t'(c[i]);
        end
        mx1_next = mag1_next[0];
        if (mag1_next[1] > mx1_next)
        begin
            mx1_next = mag1_next[1];
        end
        if (mag1_next[2] > mx1_next)
        begin
            mx1_next = mag1_next[2];
        end
    end

    always_comb
    begin
        hb = '0;
        for (int i = 0; i < CW - 1; i++)
        begin
            if (mx1_reg[i])
            begin
                hb = 5'(i);
            end
        end
        k2_next = mx1_reg[CW-1] ? 5'd0 : 5'(Q30) - hb;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag1_next[i];
                sgn1_reg[i] <= c[i][CW-1];
                mag2_reg[i] <= mag1_reg[i];
                ms3_reg[i]  <= mag2_reg[i] << k2_reg;
                ms4_reg[i]  <= ms3_reg[i];
                sq4_reg[i]  <= 64'(ms3_reg[i]) * 64'(ms3_reg[i]);
                ms5_reg[i]  <= ms4_reg[i];
            end
            mx1_reg  <= mx1_next;
            sgn2_reg <= sgn1_reg;
            k2_reg   <= k2_next;
            nz2_reg  <= mx1_reg != '0;
            sgn3_reg <= sgn2_reg;
            nz3_reg  <= nz2_reg;
            sgn4_reg <= sgn3_reg;
            nz4_reg  <= nz3_reg;
            sum5_reg <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
            sgn5_reg <= sgn4_reg;
            nz5_reg  <= nz4_reg;
        end
    end

    var_isqrt #(
        .XW(SQ_W)
    ) u_sqrt (
        .clk (clk),
        .en  (en),
        .x   (sum5_reg),
        .root(n)
    );

    var_delay #(
        .W    (3*CW+4),
        .DEPTH(SQRT_LAT)
    ) u_dly_a (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .d    ({ms5_reg[2], ms5_reg[1], ms5_reg[0], sgn5_reg, nz5_reg}),
        .q    (side_a)
    );

    assign {ms_d[2], ms_d[1], ms_d[0], sgn_d, nz_d} = side_a;

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        assign num[i] = (U_NW'(ms_d[i]) << Q30) + U_NW'(n >> 1);

        var_div #(
            .NW(U_NW),
            .DW(CW),
            .QW(U_Q)
        ) u_div (
            .clk(clk),
            .en (en),
            .num(num[i]),
            .den(n),
            .quo(q[i])
        );
    end

    var_delay #(
        .W    (4),
        .DEPTH(DIV1_LAT)
    ) u_dly_b (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .d    ({sgn_d, nz_d}),
        .q    (side_b)
    );

    assign {sgn_e, nz_e} = side_b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= sgn_e[i] ? -comp_t'(q[i][CW-1:0]) : comp_t'(q[i][CW-1:0]);
            end
            nz_reg <= nz_e;
        end
    end

    assign u  = u_reg;
    assign nz = nz_reg;
endmodule
`default_nettype wire

// ===== src/vector_alignment_rotation.sv =====
// Top level: rotation matrix that turns one 3-vector onto another, Q1.16 entries.
//
// Input channel (in_valid/in_ready) takes a vector pair a, b and a batch-end mark.
// Output channel (out_valid/out_ready) gives the nine matrix entries m00..m22,
// the degenerate flag (zero vector or near-antiparallel pair, identity given)
// and last_out, one result item per input item, in order.
// Configuration channel (cfg_valid/cfg_ready) writes antiparallel_margin; it is
// always ready; the user must write it only while no item is in flight, and the
// block does not enforce this. The pipeline holds per-vector normalization
// (32-stage square root and 32-stage dividers), cross and dot products and a
// 34-stage divider bank for the scaled v-products; one item per cycle unless stalled.
// The whole pipeline advances together; when out_valid is high and out_ready is
// low every stage holds, in_ready drops and no item is lost or repeated.
// Reset empties the pipeline and loads the margin with 16.
`default_nettype none
module vector_alignment_rotation
    import var_pkg::*;
#(
    parameter int IN_BITS = IN_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [IN_BITS-1:0]  a_x,
    input  wire logic signed [IN_BITS-1:0]  a_y,
    input  wire logic signed [IN_BITS-1:0]  a_z,
    input  wire logic signed [IN_BITS-1:0]  b_x,
    input  wire logic signed [IN_BITS-1:0]  b_y,
    input  wire logic signed [IN_BITS-1:0]  b_z,
    input  wire logic                       last_in,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [17:0]              m00,
    output logic signed [17:0]              m01,
    output logic signed [17:0]              m02,
    output logic signed [17:0]              m10,
    output logic signed [17:0]              m11,
    output logic signed [17:0]              m12,
    output logic signed [17:0]              m20,
    output logic signed [17:0]              m21,
    output logic signed [17:0]              m22,
    output logic                            degenerate,
    output logic                            last_out,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [MARGIN_W-1:0]        antiparallel_margin
);
    localparam logic signed [63:0] RND30 = 64'sd536870912;
    localparam logic signed [33:0] ONE30 = 34'sd1073741824;

    logic                  adv;
    logic [MARGIN_W-1:0]   margin_reg;
    comp_t                 ca [3];
    comp_t                 cb [3];
    comp_t                 ua [3];
    comp_t                 ub [3];
    logic                  nza;
    logic                  nzb;

    logic signed [63:0]    p1_reg [9];
    logic                  ok1_reg;
    logic signed [63:0]    c2_reg [4];
    logic                  ok2_reg;
    comp_t                 v3_reg [3];
    logic signed [33:0]    s3_reg;
    logic                  ok3_reg;
    comp_t                 v4_reg [3];
    logic signed [63:0]    p4_reg [6];
    ucomp_t                s4_reg;
    logic                  dg4_reg;
    comp_t                 v5_reg [3];
    logic [E_NW-1:0]       num5_reg [6];
    ucomp_t                s5_reg;
    logic [2:0]            sg5_reg;
    logic                  dg5_reg;
    logic signed [35:0]    e6_reg [9];
    logic                  dg6_reg;
    logic signed [17:0]    m_reg [9];
    logic                  out_valid_reg;
    logic                  degenerate_reg;
    logic                  last_reg;

    logic [E_Q:0]          q6 [6];
    logic [3*CW+3:0]       side_d;
    comp_t                 vd [3];
    logic [2:0]            sgd;
    logic                  dgd;
    logic [1:0]            vl_d;
    logic signed [35:0]    off [3];
    logic signed [35:0]    rr [9];
    logic signed [17:0]    mc [9];
    ucomp_t                half_s;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_valid)
        begin
            margin_reg <= antiparallel_margin;
        end
    end

    assign ca[0] = CW'(a_x);
    assign ca[1] = CW'(a_y);
    assign ca[2] = CW'(a_z);
    assign cb[0] = CW'(b_x);
    assign cb[1] = CW'(b_y);
    assign cb[2] = CW'(b_z);

    var_norm u_norm_a (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .c    (ca),
        .u    (ua),
        .nz   (nza)
    );

    var_norm u_norm_b (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .c    (cb),
        .u    (ub),
        .nz   (nzb)
    );

    assign half_s = {1'b0, s4_reg[CW-1:1]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg[0] <= ua[1] * ub[2];
            p1_reg[1] <= ua[2] * ub[1];
            p1_reg[2] <= ua[2] * ub[0];
            p1_reg[3] <= ua[0] * ub[2];
            p1_reg[4] <= ua[0] * ub[1];
            p1_reg[5] <= ua[1] * ub[0];
            p1_reg[6] <= ua[0] * ub[0];
            p1_reg[7] <= ua[1] * ub[1];
            p1_reg[8] <= ua[2] * ub[2];
            ok1_reg   <= nza && nzb;

            c2_reg[0] <= p1_reg[0] - p1_reg[1];
            c2_reg[1] <= p1_reg[2] - p1_reg[3];
            c2_reg[2] <= p1_reg[4] - p1_reg[5];
            c2_reg[3] <= p1_reg[6] + p1_reg[7] + p1_reg[8];
            ok2_reg   <= ok1_reg;

            for (int i = 0; i < 3; i++)
            begin
                v3_reg[i] <= CW'((c2_reg[i] + RND30) >>> Q30);
                v4_reg[i] <= v3_reg[i];
                v5_reg[i] <= v4_reg[i];
            end
            s3_reg  <= 34'((c2_reg[3] + RND30) >>> Q30) + ONE30;
            ok3_reg <= ok2_reg;

            p4_reg[0] <= v3_reg[0] * v3_reg[0];
            p4_reg[1] <= v3_reg[1] * v3_reg[1];
            p4_reg[2] <= v3_reg[2] * v3_reg[2];
            p4_reg[3] <= v3_reg[0] * v3_reg[1];
            p4_reg[4] <= v3_reg[0] * v3_reg[2];
            p4_reg[5] <= v3_reg[1] * v3_reg[2];
            s4_reg    <= s3_reg[CW-1:0];
            dg4_reg   <= !ok3_reg || s3_reg <= 34'sd0
                         || s3_reg < $signed({3'b000, margin_reg, 14'b0});

            num5_reg[0] <= $unsigned(p4_reg[1]) + $unsigned(p4_reg[2]) + E_NW'(half_s);
            num5_reg[1] <= $unsigned(p4_reg[0]) + $unsigned(p4_reg[2]) + E_NW'(half_s);
            num5_reg[2] <= $unsigned(p4_reg[0]) + $unsigned(p4_reg[1]) + E_NW'(half_s);
            for (int i = 0; i < 3; i++)
            begin
                num5_reg[3+i] <= (p4_reg[3+i][63] ? $unsigned(-p4_reg[3+i])
                                                  : $unsigned(p4_reg[3+i]))
                                 + E_NW'(half_s);
                sg5_reg[i]    <= p4_reg[3+i][63];
            end
            s5_reg  <= s4_reg;
            dg5_reg <= dg4_reg;
        end
    end

    for (genvar i = 0; i < 6; i++)
    begin : g_div
        var_div #(
            .NW(E_NW),
            .DW(CW),
            .QW(E_Q)
        ) u_div (
            .clk(clk),
            .en (adv),
            .num(num5_reg[i]),
            .den(s5_reg),
            .quo(q6[i])
        );
    end

    var_delay #(
        .W    (3*CW+4),
        .DEPTH(DIV2_LAT)
    ) u_dly_side (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .d    ({v5_reg[2], v5_reg[1], v5_reg[0], sg5_reg, dg5_reg}),
        .q    (side_d)
    );

    assign {vd[2], vd[1], vd[0], sgd, dgd} = side_d;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            off[i] = sgd[i] ? -$signed({2'b00, q6[3+i]}) : $signed({2'b00, q6[3+i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e6_reg[0] <= 36'sd1073741824 - $signed({2'b00, q6[0]});
            e6_reg[4] <= 36'sd1073741824 - $signed({2'b00, q6[1]});
            e6_reg[8] <= 36'sd1073741824 - $signed({2'b00, q6[2]});
            e6_reg[1] <= off[0] - 36'(vd[2]);
            e6_reg[3] <= off[0] + 36'(vd[2]);
            e6_reg[2] <= off[1] + 36'(vd[1]);
            e6_reg[6] <= off[1] - 36'(vd[1]);
            e6_reg[5] <= off[2] - 36'(vd[0]);
            e6_reg[7] <= off[2] + 36'(vd[0]);
            dg6_reg   <= dgd;
        end
    end

    var_delay #(
        .W    (2),
        .DEPTH(PRE_LAT)
    ) u_dly_valid (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .d    ({in_valid, last_in}),
        .q    (vl_d)
    );

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            rr[i] = (e6_reg[i] + 36'sd8192) >>> 14;
            if (rr[i] > 36'sd65536)
            begin
                mc[i] = Q16_ONE;
            end
            else if (rr[i] < -36'sd65536)
            begin
                mc[i] = -Q16_ONE;
            end
            else
            begin
                mc[i] = 18'(rr[i]);
            end
            if (dg6_reg)
            begin
                mc[i] = (i % 4 == 0) ? Q16_ONE : 18'sd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vl_d[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
            begin
                m_reg[i] <= mc[i];
            end
            degenerate_reg <= dg6_reg;
            last_reg       <= vl_d[0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign m00        = m_reg[0];
    assign m01        = m_reg[1];
    assign m02        = m_reg[2];
    assign m10        = m_reg[3];
    assign m11        = m_reg[4];
    assign m12        = m_reg[5];
    assign m20        = m_reg[6];
    assign m21        = m_reg[7];
    assign m22        = m_reg[8];
    assign degenerate = degenerate_reg;
    assign last_out   = last_reg;

    a_deg_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> m00 == Q16_ONE && m11 == Q16_ONE && m22 == Q16_ONE
            && m01 == 18'sd0 && m12 == 18'sd0 && m20 == 18'sd0)
        else $error("degenerate item without identity matrix");

    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> m00 <= Q16_ONE && m00 >= -Q16_ONE && m11 <= Q16_ONE
            && m11 >= -Q16_ONE && m22 <= Q16_ONE && m22 >= -Q16_ONE)
        else $error("diagonal entry outside saturation range");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> margin_reg == $past(antiparallel_margin))
        else $error("margin register not loaded by write");
endmodule
`default_nettype wire
